// ===== rtl/core/etq_pkg.sv =====
// shared types, constants and fixed-point helpers for the euler to quaternion pipeline
`timescale 1ns / 1ps

package etq_pkg;

  // field widths
  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned OUT_BITS   = 16;

  // full scale of one output component
  localparam int unsigned OUT_FS = (1 << (OUT_BITS - 1)) - 1;

  // angle magnitude to q30 shift
  localparam int unsigned U_SHIFT = 31 - ANGLE_BITS;

  // pipeline shape
  localparam int unsigned NUM_ANGLES   = 3;
  localparam int unsigned NUM_LANES    = 2 * NUM_ANGLES;
  localparam int unsigned NUM_COEF     = 7;
  localparam int unsigned HORNER_STEPS = NUM_COEF - 1;
  localparam int unsigned FRONT_STAGES = 2;
  localparam int unsigned BACK_STAGES  = 5;
  localparam int unsigned NUM_STAGES   = FRONT_STAGES + HORNER_STEPS + BACK_STAGES;

  // lane order: sine then cosine for x, y, z
  localparam int unsigned LANE_SX = 0;
  localparam int unsigned LANE_CX = 1;
  localparam int unsigned LANE_SY = 2;
  localparam int unsigned LANE_CY = 3;
  localparam int unsigned LANE_SZ = 4;
  localparam int unsigned LANE_CZ = 5;

  // q30 value, wide enough for every intermediate of the series
  typedef logic [30:0] qv_t;

  localparam qv_t Q_ONE  = 31'h4000_0000;
  localparam qv_t Q_HALF = 31'h2000_0000;

  // taylor coefficients (pi/2)^n/n! in q30, odd powers from 1 to 13
  localparam qv_t SIN_COEF [NUM_COEF] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
    31'd172272, 31'd3864, 31'd61
  };

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] quat_x;
    logic signed [OUT_BITS-1:0] quat_y;
    logic signed [OUT_BITS-1:0] quat_z;
    logic signed [OUT_BITS-1:0] quat_w;
  } out_item_t;

  // one series evaluation in flight
  typedef struct packed {
    qv_t u;
    qv_t u2;
    qv_t p;
  } horner_lane_t;

  typedef struct packed {
    horner_lane_t [NUM_LANES-1:0]  lane;
    logic         [NUM_ANGLES-1:0] neg;
  } horner_t;

  // q30 multiply, round half up; operands keep the result below 2^31
  function automatic qv_t qmul_u(input qv_t a, input qv_t b);
    logic [61:0] prod;
    logic [62:0] rnd;
    prod = 62'(a) * 62'(b);
    rnd  = {1'b0, prod} + 63'(Q_HALF);
    return rnd[60:30];
  endfunction

endpackage

// ===== rtl/core/euler_to_quaternion_q15.sv =====
// top level: euler angles to q1.15 unit quaternion, pipelined cell chain
`timescale 1ns / 1ps

// usage
// - input channel: in_valid_i / in_ready_o carry three signed binary angles
//   (half scale of the field is pi); one transaction is one rotation
// - output channel: out_valid_o / out_ready_i carry x, y, z, w in q1.15,
//   rounded to nearest and saturated to plus or minus full scale
// - throughput: one transaction per cycle, sustained, when out_ready_i is high
// - depth: 13 register stages (2 front cells, 6 horner cells of the
//   sine series, 5 back cells for products, sums and scaling)
// - every stage has its own valid bit; a stage loads when it is empty or
//   the stage after it moves, so bubbles close up while the output stalls
// - in_ready_o drops only when all 13 stages hold data and out_ready_i is low;
//   a stalled result holds its value until taken
// - reset clears the valid bits only; the pipeline comes up empty and ready

module euler_to_quaternion_q15
  import etq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  logic [NUM_STAGES-1:0] vld_q, vld_d, vld_in, rdy;

  // series state between the cells
  horner_t chain [HORNER_STEPS+1];

  // stage k may load when some stage from k to the end is free or the output moves
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
    assign rdy[k] = out_ready_i | ~(&vld_q[NUM_STAGES-1:k]);
  end

  // valid bits shift with the data
  assign vld_in = {vld_q[NUM_STAGES-2:0], in_valid_i};
  assign vld_d  = (vld_in & rdy) | (vld_q & ~rdy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  // argument and square
  etq_front u_front (
    .clk_i     (clk_i),
    .en_i      (rdy[FRONT_STAGES-1:0]),
    .in_item_i (in_item_i),
    .data_o    (chain[0])
  );

  // horner chain, highest coefficient first
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_cell
    etq_horner_cell #(
      .COEF_IDX (HORNER_STEPS - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (rdy[FRONT_STAGES + k]),
      .data_i (chain[k]),
      .data_o (chain[k+1])
    );
  end

  // products, sums and output register
  etq_combine u_combine (
    .clk_i      (clk_i),
    .en_i       (rdy[NUM_STAGES-1:FRONT_STAGES+HORNER_STEPS]),
    .data_i     (chain[HORNER_STEPS]),
    .out_item_o (out_item_o)
  );

  // input is refused only with every stage occupied
  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input blocked while the pipeline has a free stage");

  // an accepted transaction lands in the first stage
  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transaction missing from the first stage");

  // saturation keeps every component off the most negative code
  a_no_min_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.quat_x != OUT_MIN) && (out_item_o.quat_y != OUT_MIN) &&
                     (out_item_o.quat_z != OUT_MIN) && (out_item_o.quat_w != OUT_MIN)))
    else $error("output component at the most negative code");

endmodule

// ===== rtl/core/etq_front.sv =====
// front cells: angle to q30 series argument, then the squared argument
`timescale 1ns / 1ps

module etq_front
  import etq_pkg::*;
(
  input  logic                    clk_i,
  input  logic [FRONT_STAGES-1:0] en_i,
  input  in_item_t                in_item_i,
  output horner_t                 data_o
);

  typedef struct packed {
    qv_t  [NUM_LANES-1:0]  u;
    logic [NUM_ANGLES-1:0] neg;
  } arg_t;

  arg_t    arg_d, arg_q;
  horner_t sq_d, sq_q;

  logic [NUM_ANGLES-1:0][ANGLE_BITS-1:0] angle;
  logic [NUM_ANGLES-1:0][ANGLE_BITS-1:0] mag;
  qv_t  [NUM_ANGLES-1:0]                 u_sin;

  assign angle[0] = in_item_i.angle_x;
  assign angle[1] = in_item_i.angle_y;
  assign angle[2] = in_item_i.angle_z;

  // half angle sine on |t|, cosine as sine of the complement
  always_comb begin
    for (int i = 0; i < NUM_ANGLES; i++) begin
      arg_d.neg[i]     = angle[i][ANGLE_BITS-1];
      mag[i]           = angle[i][ANGLE_BITS-1] ? (~angle[i] + 1'b1) : angle[i];
      u_sin[i]         = qv_t'(mag[i]) << U_SHIFT;
      arg_d.u[2*i]     = u_sin[i];
      arg_d.u[2*i + 1] = Q_ONE - u_sin[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      arg_q <= arg_d;
    end
  end

  always_comb begin
    sq_d.neg = arg_q.neg;
    for (int l = 0; l < NUM_LANES; l++) begin
      sq_d.lane[l].u  = arg_q.u[l];
      sq_d.lane[l].u2 = qmul_u(arg_q.u[l], arg_q.u[l]);
      sq_d.lane[l].p  = SIN_COEF[NUM_COEF-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sq_q <= sq_d;
    end
  end

  assign data_o = sq_q;

endmodule

// ===== rtl/core/etq_horner_cell.sv =====
// one horner step of the sine series for all six lanes
`timescale 1ns / 1ps

module etq_horner_cell
  import etq_pkg::*;
#(
  parameter int unsigned COEF_IDX = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  horner_t data_i,
  output horner_t data_o
);

  localparam qv_t COEF = SIN_COEF[COEF_IDX];

  horner_t data_d, data_q;
  qv_t [NUM_LANES-1:0] t;

  // a step that would go below zero gives zero
  always_comb begin
    data_d = data_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      t[l]              = qmul_u(data_i.lane[l].p, data_i.lane[l].u2);
      data_d.lane[l].p  = (t[l] > COEF) ? '0 : COEF - t[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/etq_combine.sv =====
// back cells: finish sines, triple products, sums and output scaling
`timescale 1ns / 1ps

module etq_combine
  import etq_pkg::*;
(
  input  logic                   clk_i,
  input  logic [BACK_STAGES-1:0] en_i,
  input  horner_t                data_i,
  output out_item_t              out_item_o
);

  localparam int unsigned PW = 32 + OUT_BITS;
  localparam int unsigned RW = PW - 30;

  // pair product slots
  localparam int unsigned P_SXCY = 0;
  localparam int unsigned P_CXSY = 1;
  localparam int unsigned P_CXCY = 2;
  localparam int unsigned P_SXSY = 3;

  typedef struct packed {
    qv_t  [NUM_LANES-1:0] mag;
    logic [NUM_LANES-1:0] neg;
  } sincos_t;

  typedef struct packed {
    qv_t  [3:0] mag;
    logic [3:0] neg;
    qv_t        sz;
    qv_t        cz;
    logic       nz;
  } pair_t;

  typedef struct packed {
    logic [7:0][31:0] term;
  } term_t;

  typedef struct packed {
    logic [3:0][31:0] mag;
    logic [3:0]       neg;
  } sum_t;

  sincos_t   sc_d, sc_q;
  pair_t     pr_d, pr_q;
  term_t     tm_d, tm_q;
  sum_t      sm_d, sm_q;
  out_item_t out_d, out_q;

  qv_t              [NUM_LANES-1:0] pu;
  logic [3:0][32:0]                 sum;

  function automatic logic [31:0] to_signed(input logic neg, input qv_t mag);
    logic [31:0] v;
    v = {1'b0, mag};
    return neg ? (32'd0 - v) : v;
  endfunction

  // round |v| * fs to nearest, saturate, restore sign
  function automatic logic [OUT_BITS-1:0] to_out(input logic neg, input logic [31:0] mag);
    logic [PW-1:0]       prod;
    logic [PW-1:0]       rnd;
    logic [RW-1:0]       r;
    logic [OUT_BITS-1:0] rc;
    prod = PW'(mag) * PW'(OUT_FS);
    rnd  = prod + PW'(Q_HALF);
    r    = rnd[PW-1:30];
    rc   = (r > RW'(OUT_FS)) ? OUT_BITS'(OUT_FS) : r[OUT_BITS-1:0];
    return neg ? (~rc + 1'b1) : rc;
  endfunction

  // stage: last multiply of the series, clamp to one
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      pu[l]        = qmul_u(data_i.lane[l].p, data_i.lane[l].u);
      sc_d.mag[l]  = (pu[l] > Q_ONE) ? Q_ONE : pu[l];
    end
    for (int i = 0; i < NUM_ANGLES; i++) begin
      sc_d.neg[2*i]     = data_i.neg[i];
      sc_d.neg[2*i + 1] = 1'b0;
    end
  end

  // stage: products of the x and y terms
  always_comb begin
    pr_d.mag[P_SXCY] = qmul_u(sc_q.mag[LANE_SX], sc_q.mag[LANE_CY]);
    pr_d.neg[P_SXCY] = sc_q.neg[LANE_SX] ^ sc_q.neg[LANE_CY];
    pr_d.mag[P_CXSY] = qmul_u(sc_q.mag[LANE_CX], sc_q.mag[LANE_SY]);
    pr_d.neg[P_CXSY] = sc_q.neg[LANE_CX] ^ sc_q.neg[LANE_SY];
    pr_d.mag[P_CXCY] = qmul_u(sc_q.mag[LANE_CX], sc_q.mag[LANE_CY]);
    pr_d.neg[P_CXCY] = sc_q.neg[LANE_CX] ^ sc_q.neg[LANE_CY];
    pr_d.mag[P_SXSY] = qmul_u(sc_q.mag[LANE_SX], sc_q.mag[LANE_SY]);
    pr_d.neg[P_SXSY] = sc_q.neg[LANE_SX] ^ sc_q.neg[LANE_SY];
    pr_d.sz          = sc_q.mag[LANE_SZ];
    pr_d.cz          = sc_q.mag[LANE_CZ];
    pr_d.nz          = sc_q.neg[LANE_SZ];
  end

  // stage: the eight triple products, cosine z never negative
  always_comb begin
    tm_d.term[0] = to_signed(pr_q.neg[P_SXCY], qmul_u(pr_q.mag[P_SXCY], pr_q.cz));
    tm_d.term[1] = to_signed(pr_q.neg[P_CXSY] ^ pr_q.nz, qmul_u(pr_q.mag[P_CXSY], pr_q.sz));
    tm_d.term[2] = to_signed(pr_q.neg[P_CXSY], qmul_u(pr_q.mag[P_CXSY], pr_q.cz));
    tm_d.term[3] = to_signed(pr_q.neg[P_SXCY] ^ pr_q.nz, qmul_u(pr_q.mag[P_SXCY], pr_q.sz));
    tm_d.term[4] = to_signed(pr_q.neg[P_CXCY] ^ pr_q.nz, qmul_u(pr_q.mag[P_CXCY], pr_q.sz));
    tm_d.term[5] = to_signed(pr_q.neg[P_SXSY], qmul_u(pr_q.mag[P_SXSY], pr_q.cz));
    tm_d.term[6] = to_signed(pr_q.neg[P_CXCY], qmul_u(pr_q.mag[P_CXCY], pr_q.cz));
    tm_d.term[7] = to_signed(pr_q.neg[P_SXSY] ^ pr_q.nz, qmul_u(pr_q.mag[P_SXSY], pr_q.sz));
  end

  // stage: x = a - b, y = c + d, z = e - f, w = g + h, split to sign and magnitude
  always_comb begin
    sum[0] = {tm_q.term[0][31], tm_q.term[0]} - {tm_q.term[1][31], tm_q.term[1]};
    sum[1] = {tm_q.term[2][31], tm_q.term[2]} + {tm_q.term[3][31], tm_q.term[3]};
    sum[2] = {tm_q.term[4][31], tm_q.term[4]} - {tm_q.term[5][31], tm_q.term[5]};
    sum[3] = {tm_q.term[6][31], tm_q.term[6]} + {tm_q.term[7][31], tm_q.term[7]};
    for (int c = 0; c < 4; c++) begin
      sm_d.neg[c] = sum[c][32];
      sm_d.mag[c] = sum[c][32] ? (~sum[c][31:0] + 1'b1) : sum[c][31:0];
    end
  end

  // stage: scale to output full scale
  always_comb begin
    out_d.quat_x = to_out(sm_q.neg[0], sm_q.mag[0]);
    out_d.quat_y = to_out(sm_q.neg[1], sm_q.mag[1]);
    out_d.quat_z = to_out(sm_q.neg[2], sm_q.mag[2]);
    out_d.quat_w = to_out(sm_q.neg[3], sm_q.mag[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) sc_q  <= sc_d;
    if (en_i[1]) pr_q  <= pr_d;
    if (en_i[2]) tm_q  <= tm_d;
    if (en_i[3]) sm_q  <= sm_d;
    if (en_i[4]) out_q <= out_d;
  end

  assign out_item_o = out_q;

endmodule

// ===== dv/euler_to_quaternion_q15_tb.sv =====
// testbench for the euler angle to q1.15 quaternion pipeline
`timescale 1ns / 1ps

// what is checked
// - every result matches a bit-exact fixed-point prediction of the rotation:
//   half-angle sine and cosine by a q30 taylor series, triple products with
//   rounded q30 multiplies, then scaling to q1.15 with saturation
// - results come back in order, one per accepted transaction, none extra
// - directed corner angles first, then long random streams under three
//   idling mixes, plus one long output stall that fills the pipeline

module euler_to_quaternion_q15_tb;
  import etq_pkg::*;

  localparam int CLK_HALF_NS  = 5;
  localparam int RESET_CYCLES = 8;
  // pipeline is 13 stages deep; give stray results time to show up
  localparam int SETTLE_CYCLES = 20;
  // cycles with no transaction on either side before the run is declared hung
  localparam int STUCK_LIMIT   = 2000;
  localparam int OUTPUT_HOLD   = 150;
  localparam int BURST_ITEMS   = 40;
  localparam int PHASE_ITEMS   = 630;

  // q30 helpers for the predictor
  localparam longint unsigned Q30_ONE  = 64'd1 << 30;
  localparam longint unsigned Q30_HALF = 64'd1 << 29;
  localparam longint unsigned Q15_FULL = (64'd1 << (OUT_BITS - 1)) - 1;
  localparam longint unsigned ANGLE_WRAP = 64'd1 << ANGLE_BITS;

  // (pi/2)^n / n! in q30 for n = 1, 3, ..., 13
  localparam longint unsigned TAYLOR_Q30 [7] = '{
    64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
    64'd172272, 64'd3864, 64'd61
  };

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // idling knobs, percent of cycles
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  // request for a long output stall, picked up by the receiver process
  int rx_hold_req = 0;
  int errors = 0;

  out_item_t pending_quats [$];

  euler_to_quaternion_q15 DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    forever #CLK_HALF_NS clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // q30 multiply, round half up
  function automatic longint unsigned q30_mul(input longint unsigned a,
                                              input longint unsigned b);
    return (a * b + Q30_HALF) >> 30;
  endfunction

  // magnitudes are multiplied, sign applied after (ties away from zero)
  function automatic longint q30_mul_signed(input longint a, input longint b);
    logic             neg;
    longint unsigned  mag;
    neg = (a < 0) != (b < 0);
    mag = q30_mul(longint'(a < 0 ? -a : a), longint'(b < 0 ? -b : b));
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // sin(u*pi/2) for u in [0, 1.0] q30, horner form clamped at zero per step
  function automatic longint unsigned quarter_sine(input longint unsigned u);
    longint unsigned u_sq;
    longint unsigned acc;
    longint unsigned term;
    u_sq = q30_mul(u, u);
    acc  = TAYLOR_Q30[6];
    for (int k = 5; k >= 0; k--) begin
      term = q30_mul(acc, u_sq);
      acc  = (term > TAYLOR_Q30[k]) ? 64'd0 : TAYLOR_Q30[k] - term;
    end
    acc = q30_mul(acc, u);
    return (acc > Q30_ONE) ? Q30_ONE : acc;
  endfunction

  // sine and cosine of half the angle, q30 signed
  task automatic half_angle_sincos(input logic [ANGLE_BITS-1:0] angle,
                                   output longint sin_h, output longint cos_h);
    logic            neg;
    longint unsigned mag;
    longint unsigned u;
    longint unsigned s_mag;
    neg   = angle[ANGLE_BITS-1];
    mag   = neg ? ANGLE_WRAP - longint'(angle) : longint'(angle);
    u     = mag << (31 - ANGLE_BITS);
    s_mag = quarter_sine(u);
    sin_h = neg ? -longint'(s_mag) : longint'(s_mag);
    cos_h = longint'(quarter_sine(Q30_ONE - u));
  endtask

  function automatic longint rot_product(input longint a, input longint b,
                                         input longint c);
    return q30_mul_signed(q30_mul_signed(a, b), c);
  endfunction

  // q30 to q1.15, round to nearest away from zero, saturate
  function automatic logic [OUT_BITS-1:0] to_q15(input longint v);
    logic            neg;
    longint unsigned mag;
    longint unsigned r;
    neg = v < 0;
    mag = neg ? -v : v;
    r   = (mag * Q15_FULL + Q30_HALF) >> 30;
    if (r > Q15_FULL) r = Q15_FULL;
    return neg ? OUT_BITS'(-longint'(r)) : OUT_BITS'(r);
  endfunction

  task automatic predict_quaternion(input in_item_t rot, output out_item_t q);
    longint sx, cx, sy, cy, sz, cz;
    half_angle_sincos(rot.angle_x, sx, cx);
    half_angle_sincos(rot.angle_y, sy, cy);
    half_angle_sincos(rot.angle_z, sz, cz);
    q.quat_x = to_q15(rot_product(sx, cy, cz) - rot_product(cx, sy, sz));
    q.quat_y = to_q15(rot_product(cx, sy, cz) + rot_product(sx, cy, sz));
    q.quat_z = to_q15(rot_product(cx, cy, sz) - rot_product(sx, sy, cz));
    q.quat_w = to_q15(rot_product(cx, cy, cz) + rot_product(sx, sy, sz));
  endtask

  // ---------------------------------------------------------------------
  // scoreboard: predict on input transaction, compare on output transaction
  // ---------------------------------------------------------------------

  function automatic void check_component(input string name,
                                          input logic signed [OUT_BITS-1:0] want,
                                          input logic signed [OUT_BITS-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    out_item_t predicted;
    out_item_t oldest;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_quaternion(in_item_i, predicted);
        pending_quats.push_back(predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_quats.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item_o);
        end else begin
          oldest = pending_quats.pop_front();
          check_component("quat_x", oldest.quat_x, out_item_o.quat_x);
          check_component("quat_y", oldest.quat_y, out_item_o.quat_y);
          check_component("quat_z", oldest.quat_z, out_item_o.quat_z);
          check_component("quat_w", oldest.quat_w, out_item_o.quat_w);
        end
      end
    end
  end

  // receiver: random idling, or a long hold counted here when requested
  always @(posedge clk_i) begin : receiver
    int hold_left;
    if (rx_hold_req != 0) begin
      hold_left   = rx_hold_req;
      rx_hold_req = 0;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // hang detector: any transaction on either side restarts the count
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck = 0;
      else stuck++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  function automatic in_item_t make_rotation(input logic [ANGLE_BITS-1:0] ax,
                                             input logic [ANGLE_BITS-1:0] ay,
                                             input logic [ANGLE_BITS-1:0] az);
    in_item_t rot;
    rot.angle_x = ax;
    rot.angle_y = ay;
    rot.angle_z = az;
    return rot;
  endfunction

  // mostly uniform, with a share of corner and near-zero angles
  function automatic logic [ANGLE_BITS-1:0] random_angle();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(6))
          0: return 16'h8000;   // -pi
          1: return 16'h7fff;   // just under pi
          2: return 16'h4000;   // pi/2
          3: return 16'hc000;   // -pi/2
          4: return 16'h0001;
          5: return 16'hffff;
          default: return 16'h0000;
        endcase
      end
      1: return ANGLE_BITS'($urandom_range(16) - 8);
      default: return ANGLE_BITS'($urandom_range(65535));
    endcase
  endfunction

  function automatic in_item_t random_rotation();
    return make_rotation(random_angle(), random_angle(), random_angle());
  endfunction

  // offer one rotation, return at the edge that accepts it
  task automatic send_rotation(input in_item_t rot);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= rot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // sender goes quiet until every result is back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    // let the scoreboard record the transaction accepted at the last edge
    @(posedge clk_i);
    while (pending_quats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // corner angles: zero, both ends of the range, quarter turns, mixed signs
  task automatic test_corner_angles();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_rotation(make_rotation(16'h0000, 16'h0000, 16'h0000));
    send_rotation(make_rotation(16'h8000, 16'h0000, 16'h0000));
    send_rotation(make_rotation(16'h0000, 16'h8000, 16'h0000));
    send_rotation(make_rotation(16'h0000, 16'h0000, 16'h8000));
    send_rotation(make_rotation(16'h7fff, 16'h0000, 16'h0000));
    send_rotation(make_rotation(16'h0000, 16'h7fff, 16'h0000));
    send_rotation(make_rotation(16'h0000, 16'h0000, 16'h7fff));
    send_rotation(make_rotation(16'h8000, 16'h8000, 16'h8000));
    send_rotation(make_rotation(16'h7fff, 16'h7fff, 16'h7fff));
    send_rotation(make_rotation(16'h8000, 16'h7fff, 16'h8000));
    send_rotation(make_rotation(16'h4000, 16'h0000, 16'h0000));
    send_rotation(make_rotation(16'h0000, 16'hc000, 16'h0000));
    send_rotation(make_rotation(16'h4000, 16'h4000, 16'h4000));
    send_rotation(make_rotation(16'hc000, 16'h4000, 16'hc000));
    send_rotation(make_rotation(16'h0001, 16'hffff, 16'h0001));
    send_rotation(make_rotation(16'h2000, 16'he000, 16'h6000));
    send_rotation(make_rotation(16'h7fff, 16'h8000, 16'h0001));
    send_rotation(make_rotation(16'h5555, 16'haaaa, 16'h5555));
    send_rotation(make_rotation(16'haaaa, 16'h5555, 16'haaaa));
    wait_for_drain();
  endtask

  // output held off long enough that all stages fill and the input stalls
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = OUTPUT_HOLD;
    repeat (BURST_ITEMS) send_rotation(random_rotation());
    wait_for_drain();
  endtask

  task automatic test_random_stream(input int n, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) send_rotation(random_rotation());
    wait_for_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_angles();
    test_output_backpressure();
    // sender sparse idling, receiver mostly stalled
    test_random_stream(PHASE_ITEMS, 14, 64);
    // then the other way round
    test_random_stream(PHASE_ITEMS, 64, 14);
    // full rate both sides
    test_random_stream(PHASE_ITEMS, 0, 0);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
